// ----- hdl/code128b_row_rasterizer_macros.svh -----
// ----------------------------------------------------------------------------
// Code 128 row rasterizer assertion macros
// Shared concurrent assertion forms used by the rasterizer's checks.
// ----------------------------------------------------------------------------
`ifndef CODE128B_ROW_RASTERIZER_MACROS_SVH
`define CODE128B_ROW_RASTERIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define C128R_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define C128R_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/c128r_pkg.sv -----
// ----------------------------------------------------------------------------
// Code 128 row rasterizer package
// Payload types, slot commands, symbol patterns and shared constants.
// ----------------------------------------------------------------------------
package c128r_pkg;

   localparam int WORD_PIXELS        = 32;
   localparam int MODULES_PER_SYMBOL = 11;
   localparam int MAX_BAR_WIDTH      = 16;
   localparam int SLOT_PIXELS        = MODULES_PER_SYMBOL * MAX_BAR_WIDTH;

   localparam int CHAR_W   = 8;
   localparam int SYM_W    = 7;
   localparam int BAR_W_W  = 5;
   localparam int FILL_W   = $clog2(WORD_PIXELS + 1);
   localparam int LEFT_W   = $clog2(SLOT_PIXELS + 1);
   localparam int PROD_W   = 14;
   localparam int RECIP_W  = 23;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] REG_BAR_WIDTH = '0;
   localparam logic [BAR_W_W-1:0]   BAR_WIDTH_RESET = 5'd1;
   localparam logic [BAR_W_W-1:0]   BAR_WIDTH_MAX   = 5'd16;

   // Symbol codes.
   localparam logic [SYM_W-1:0] SYM_START_B = 7'd104;
   localparam logic [SYM_W-1:0] SYM_STOP    = 7'd106;
   localparam logic [SYM_W-1:0] SYM_QUIET   = 7'd107;
   localparam logic [SYM_W-1:0] SYM_TERM    = 7'd108;
   localparam logic [SYM_W-1:0] CHECK_MOD   = 7'd103;
   localparam logic [SYM_W-1:0] CHECK_INIT  = 7'd1;
   localparam logic [SYM_W-1:0] WEIGHT_INIT = 7'd1;

   localparam logic [CHAR_W-1:0] CHAR_LOW  = 8'd32;
   localparam logic [CHAR_W-1:0] CHAR_HIGH = 8'd126;

   // floor(x * RECIP >> RECIP_SHIFT) is floor(x / 103) or one less for x < 2^14.
   localparam int RECIP       = 636;
   localparam int RECIP_SHIFT = 16;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              last_char;
   } req_payload_type;

   typedef struct packed {
      logic [WORD_PIXELS-1:0] pixel_word;
      logic [FILL_W-1:0]      pixel_count;
      logic                   row_end;
      logic                   bad_char;
   } rsp_payload_type;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             row_done;
      logic             bad;
   } slot_cmd_type;

   typedef enum logic [3:0] {
      FE_IDLE,
      FE_QUIET_HEAD,
      FE_START,
      FE_VALUE,
      FE_CHECK,
      FE_STOP,
      FE_TERM,
      FE_QUIET_TAIL,
      FE_BAD
   } front_state_type;

   localparam int SYMBOL_COUNT = 109;

   localparam logic [MODULES_PER_SYMBOL-1:0] SYM_PATTERN [0:SYMBOL_COUNT-1] = '{
      11'b11011001100, 11'b11001101100, 11'b11001100110, 11'b10010011000,
      11'b10010001100, 11'b10001001100, 11'b10011001000, 11'b10011000100,
      11'b10001100100, 11'b11001001000, 11'b11001000100, 11'b11000100100,
      11'b10110011100, 11'b10011011100, 11'b10011001110, 11'b10111001100,
      11'b10011101100, 11'b10011100110, 11'b11001110010, 11'b11001011100,
      11'b11001001110, 11'b11011100100, 11'b11001110100, 11'b11101101110,
      11'b11101001100, 11'b11100101100, 11'b11100100110, 11'b11101100100,
      11'b11100110100, 11'b11100110010, 11'b11011011000, 11'b11011000110,
      11'b11000110110, 11'b10100011000, 11'b10001011000, 11'b10001000110,
      11'b10110001000, 11'b10001101000, 11'b10001100010, 11'b11010001000,
      11'b11000101000, 11'b11000100010, 11'b10110111000, 11'b10110001110,
      11'b10001101110, 11'b10111011000, 11'b10111000110, 11'b10001110110,
      11'b11101110110, 11'b11010001110, 11'b11000101110, 11'b11011101000,
      11'b11011100010, 11'b11011101110, 11'b11101011000, 11'b11101000110,
      11'b11100010110, 11'b11101101000, 11'b11101100010, 11'b11100011010,
      11'b11101111010, 11'b11001000010, 11'b11110001010, 11'b10100110000,
      11'b10100001100, 11'b10010110000, 11'b10010000110, 11'b10000101100,
      11'b10000100110, 11'b10110010000, 11'b10110000100, 11'b10011010000,
      11'b10011000010, 11'b10000110100, 11'b10000110010, 11'b11000010010,
      11'b11001010000, 11'b11110111010, 11'b11000010100, 11'b10001111010,
      11'b10100111100, 11'b10010111100, 11'b10010011110, 11'b10111100100,
      11'b10011110100, 11'b10011110010, 11'b11110100100, 11'b11110010100,
      11'b11110010010, 11'b11011011110, 11'b11011110110, 11'b11110110110,
      11'b10101111000, 11'b10100011110, 11'b10001011110, 11'b10111101000,
      11'b10111100010, 11'b11110101000, 11'b11110100010, 11'b10111011110,
      11'b10111101110, 11'b11101011110, 11'b11110101110, 11'b11010000100,
      11'b11010010000, 11'b11010011100, 11'b11000111010, 11'b00000000000,
      11'b11000000000
   };

   // Module pattern of a symbol, first module in the top bit.
   function automatic logic [MODULES_PER_SYMBOL-1:0] sym_pattern(input logic [SYM_W-1:0] sym);
      logic [MODULES_PER_SYMBOL-1:0] pat;
      pat = '0;
      if (sym < SYM_W'(SYMBOL_COUNT)) begin
         pat = SYM_PATTERN[sym];
      end
      return pat;
   endfunction

endpackage

// ----- hdl/c128r_front.sv -----
// ----------------------------------------------------------------------------
// Code 128 row rasterizer front end
// Accepts characters, keeps the checksum and queues one command per slot.
// ----------------------------------------------------------------------------
module c128r_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  c128r_pkg::req_payload_type  req_payload,
   output logic                        queue_push,
   output c128r_pkg::slot_cmd_type     queue_cmd,
   input  logic                        queue_full
);

   c128r_pkg::front_state_type state_ff, state_in;

   logic [c128r_pkg::SYM_W-1:0]   value_ff, value_in;
   logic                          last_ff, last_in;
   logic                          in_row_ff, in_row_in;
   logic [c128r_pkg::SYM_W-1:0]   weight_ff, weight_in;
   logic [c128r_pkg::SYM_W-1:0]   check_ff, check_in;
   logic [1:0]                    pipe_ff, pipe_in;
   logic [c128r_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [c128r_pkg::PROD_W-1:0]  sum_ff, sum_in;
   logic [c128r_pkg::SYM_W-1:0]   quot_ff, quot_in;

   logic                          char_bad;
   logic [c128r_pkg::CHAR_W-1:0]  char_offset;
   logic [c128r_pkg::PROD_W-1:0]  sum_now;
   logic [c128r_pkg::RECIP_W-1:0] scaled;
   logic [c128r_pkg::PROD_W-1:0]  rem;
   logic [c128r_pkg::PROD_W-1:0]  rem_fold;

   always_comb begin
      char_bad    = (req_payload.char_code < c128r_pkg::CHAR_LOW) ||
                    (req_payload.char_code > c128r_pkg::CHAR_HIGH);
      char_offset = req_payload.char_code - c128r_pkg::CHAR_LOW;

      // Checksum: multiply, then reduce modulo 103 by reciprocal and one fix-up.
      sum_now = c128r_pkg::PROD_W'(check_ff) + prod_ff;
      scaled  = c128r_pkg::RECIP_W'(sum_now) *
                c128r_pkg::RECIP_W'(c128r_pkg::RECIP);
      rem     = sum_ff - c128r_pkg::PROD_W'(quot_ff) *
                c128r_pkg::PROD_W'(c128r_pkg::CHECK_MOD);
      rem_fold = (rem >= c128r_pkg::PROD_W'(c128r_pkg::CHECK_MOD)) ?
                 rem - c128r_pkg::PROD_W'(c128r_pkg::CHECK_MOD) : rem;
   end

   always_comb begin
      state_in  = state_ff;
      value_in  = value_ff;
      last_in   = last_ff;
      in_row_in = in_row_ff;
      weight_in = weight_ff;
      check_in  = check_ff;
      pipe_in   = {pipe_ff[0], 1'b0};
      prod_in   = prod_ff;
      sum_in    = sum_ff;
      quot_in   = quot_ff;

      req_stall  = (state_ff != c128r_pkg::FE_IDLE);
      queue_push = 1'b0;
      queue_cmd  = '{symbol: value_ff, row_done: 1'b0, bad: 1'b0};

      if (pipe_ff[0]) begin
         sum_in  = sum_now;
         quot_in = scaled[c128r_pkg::RECIP_W-1:c128r_pkg::RECIP_SHIFT];
      end
      if (pipe_ff[1]) begin
         check_in = rem_fold[c128r_pkg::SYM_W-1:0];
      end

      unique case (state_ff)
         c128r_pkg::FE_IDLE: begin
            if (req_valid) begin
               value_in = char_offset[c128r_pkg::SYM_W-1:0];
               last_in  = req_payload.last_char;
               if (char_bad) begin
                  in_row_in = 1'b0;
                  weight_in = c128r_pkg::WEIGHT_INIT;
                  check_in  = c128r_pkg::CHECK_INIT;
                  state_in  = c128r_pkg::FE_BAD;
               end else begin
                  prod_in = c128r_pkg::PROD_W'(char_offset[c128r_pkg::SYM_W-1:0]) *
                            c128r_pkg::PROD_W'(weight_ff);
                  pipe_in[0] = 1'b1;
                  weight_in  = (weight_ff == c128r_pkg::CHECK_MOD - 7'd1) ?
                               '0 : weight_ff + 7'd1;
                  in_row_in  = 1'b1;
                  state_in   = in_row_ff ? c128r_pkg::FE_VALUE : c128r_pkg::FE_QUIET_HEAD;
               end
            end
         end
         c128r_pkg::FE_QUIET_HEAD: begin
            queue_cmd.symbol = c128r_pkg::SYM_QUIET;
            queue_push       = !queue_full;
            if (!queue_full) state_in = c128r_pkg::FE_START;
         end
         c128r_pkg::FE_START: begin
            queue_cmd.symbol = c128r_pkg::SYM_START_B;
            queue_push       = !queue_full;
            if (!queue_full) state_in = c128r_pkg::FE_VALUE;
         end
         c128r_pkg::FE_VALUE: begin
            queue_push = !queue_full;
            if (!queue_full) begin
               state_in = last_ff ? c128r_pkg::FE_CHECK : c128r_pkg::FE_IDLE;
            end
         end
         c128r_pkg::FE_CHECK: begin
            // The checksum symbol waits for the reduction pipeline to drain.
            queue_cmd.symbol = check_ff;
            queue_push       = !queue_full && (pipe_ff == 2'b00);
            if (!queue_full && (pipe_ff == 2'b00)) state_in = c128r_pkg::FE_STOP;
         end
         c128r_pkg::FE_STOP: begin
            queue_cmd.symbol = c128r_pkg::SYM_STOP;
            queue_push       = !queue_full;
            if (!queue_full) state_in = c128r_pkg::FE_TERM;
         end
         c128r_pkg::FE_TERM: begin
            queue_cmd.symbol = c128r_pkg::SYM_TERM;
            queue_push       = !queue_full;
            if (!queue_full) state_in = c128r_pkg::FE_QUIET_TAIL;
         end
         c128r_pkg::FE_QUIET_TAIL: begin
            queue_cmd.symbol   = c128r_pkg::SYM_QUIET;
            queue_cmd.row_done = 1'b1;
            queue_push         = !queue_full;
            if (!queue_full) begin
               in_row_in = 1'b0;
               weight_in = c128r_pkg::WEIGHT_INIT;
               check_in  = c128r_pkg::CHECK_INIT;
               state_in  = c128r_pkg::FE_IDLE;
            end
         end
         c128r_pkg::FE_BAD: begin
            queue_cmd.bad = 1'b1;
            queue_push    = !queue_full;
            if (!queue_full) state_in = c128r_pkg::FE_IDLE;
         end
         default: begin
            state_in = c128r_pkg::FE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= c128r_pkg::FE_IDLE;
         in_row_ff <= 1'b0;
         weight_ff <= c128r_pkg::WEIGHT_INIT;
         check_ff  <= c128r_pkg::CHECK_INIT;
         pipe_ff   <= 2'b00;
      end else begin
         state_ff  <= state_in;
         in_row_ff <= in_row_in;
         weight_ff <= weight_in;
         check_ff  <= check_in;
         pipe_ff   <= pipe_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      last_ff  <= last_in;
      prod_ff  <= prod_in;
      sum_ff   <= sum_in;
      quot_ff  <= quot_in;
   end

endmodule

// ----- hdl/c128r_queue.sv -----
// ----------------------------------------------------------------------------
// Code 128 row rasterizer slot queue
// Small first-in first-out buffer of slot commands between the two halves.
// ----------------------------------------------------------------------------
module c128r_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  c128r_pkg::slot_cmd_type  push_cmd,
   output logic                     full,
   input  logic                     pop,
   output c128r_pkg::slot_cmd_type  pop_cmd,
   output logic                     empty
);

   c128r_pkg::slot_cmd_type entry_ff [c128r_pkg::FIFO_DEPTH];

   logic [c128r_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [c128r_pkg::FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [c128r_pkg::FIFO_CNT_W-1:0] count_ff, count_in;

   logic do_push;
   logic do_pop;

   always_comb begin
      full    = (count_ff == c128r_pkg::FIFO_CNT_W'(c128r_pkg::FIFO_DEPTH));
      empty   = (count_ff == '0);
      do_push = push && !full;
      do_pop  = pop && !empty;
      pop_cmd = entry_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == c128r_pkg::FIFO_PTR_W'(c128r_pkg::FIFO_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == c128r_pkg::FIFO_PTR_W'(c128r_pkg::FIFO_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- hdl/c128r_back.sv -----
// ----------------------------------------------------------------------------
// Code 128 row rasterizer back end
// Expands slot commands into pixels and packs them into output words.
// ----------------------------------------------------------------------------
module c128r_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [c128r_pkg::BAR_W_W-1:0]        bar_width,
   input  logic                                 queue_empty,
   input  c128r_pkg::slot_cmd_type              queue_cmd,
   output logic                                 queue_pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output c128r_pkg::rsp_payload_type           rsp_payload
);

   localparam int SP = c128r_pkg::SLOT_PIXELS;
   localparam int WP = c128r_pkg::WORD_PIXELS;

   logic                                loaded_ff, loaded_in;
   logic                                row_done_ff, row_done_in;
   logic [SP-1:0]                       bits_ff, bits_in;
   logic [c128r_pkg::LEFT_W-1:0]        left_ff, left_in;
   logic [WP-1:0]                       acc_ff, acc_in;
   logic [c128r_pkg::FILL_W-1:0]        fill_ff, fill_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   c128r_pkg::rsp_payload_type          rsp_data_ff, rsp_data_in;

   logic [c128r_pkg::BAR_W_W-1:0]       bw_eff;
   logic [c128r_pkg::MODULES_PER_SYMBOL-1:0] pattern;
   logic [SP-1:0]                       expanded;
   logic [c128r_pkg::LEFT_W-1:0]        slot_len;
   logic [c128r_pkg::FILL_W-1:0]        space;
   logic [c128r_pkg::FILL_W-1:0]        take;
   logic [c128r_pkg::FILL_W-1:0]        new_fill;
   logic [WP-1:0]                       merged;
   logic                                last_chunk;
   logic                                emit_word;
   logic                                out_free;
   int                                  idx;

   // Slot expansion: every module repeated bw_eff times, first pixel on top.
   always_comb begin
      idx = 0;
      if (bar_width == '0) begin
         bw_eff = c128r_pkg::BAR_WIDTH_RESET;
      end else if (bar_width > c128r_pkg::BAR_WIDTH_MAX) begin
         bw_eff = c128r_pkg::BAR_WIDTH_MAX;
      end else begin
         bw_eff = bar_width;
      end
      pattern  = c128r_pkg::sym_pattern(queue_cmd.symbol);
      slot_len = c128r_pkg::LEFT_W'(bw_eff) *
                 c128r_pkg::LEFT_W'(c128r_pkg::MODULES_PER_SYMBOL);
      expanded = '0;
      for (int w = 1; w <= c128r_pkg::MAX_BAR_WIDTH; w++) begin
         if (bw_eff == c128r_pkg::BAR_W_W'(w)) begin
            for (int m = 0; m < c128r_pkg::MODULES_PER_SYMBOL; m++) begin
               for (int p = 0; p < c128r_pkg::MAX_BAR_WIDTH; p++) begin
                  if (p < w) begin
                     idx = SP - 1 - (m * w + p);
                     expanded[idx] = pattern[c128r_pkg::MODULES_PER_SYMBOL - 1 - m];
                  end
               end
            end
         end
      end
   end

   always_comb begin
      space = c128r_pkg::FILL_W'(WP) - fill_ff;
      if (c128r_pkg::LEFT_W'(space) < left_ff) begin
         take = space;
      end else begin
         take = left_ff[c128r_pkg::FILL_W-1:0];
      end
      new_fill   = fill_ff + take;
      // Pixels past the end of the slot are zero, so no mask is needed.
      merged     = acc_ff | (bits_ff[SP-1 -: WP] >> fill_ff);
      last_chunk = (c128r_pkg::LEFT_W'(take) == left_ff);
      emit_word  = (new_fill == c128r_pkg::FILL_W'(WP)) || (last_chunk && row_done_ff);
      out_free   = !rsp_valid_ff || !rsp_stall;

      loaded_in    = loaded_ff;
      row_done_in  = row_done_ff;
      bits_in      = bits_ff;
      left_in      = left_ff;
      acc_in       = acc_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      queue_pop    = 1'b0;

      if (loaded_ff) begin
         if (!emit_word || out_free) begin
            bits_in   = bits_ff << take;
            left_in   = left_ff - c128r_pkg::LEFT_W'(take);
            loaded_in = !last_chunk;
            if (emit_word) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.pixel_word  = merged;
               rsp_data_in.pixel_count = new_fill;
               rsp_data_in.row_end     = last_chunk && row_done_ff;
               rsp_data_in.bad_char    = 1'b0;
               acc_in                  = '0;
               fill_in                 = '0;
            end else begin
               acc_in  = merged;
               fill_in = new_fill;
            end
         end
      end else if (!queue_empty) begin
         if (queue_cmd.bad) begin
            // A rejected character drops whatever part of the row is pending.
            if (out_free) begin
               queue_pop               = 1'b1;
               rsp_valid_in            = 1'b1;
               rsp_data_in.pixel_word  = '0;
               rsp_data_in.pixel_count = '0;
               rsp_data_in.row_end     = 1'b1;
               rsp_data_in.bad_char    = 1'b1;
               acc_in                  = '0;
               fill_in                 = '0;
            end
         end else begin
            queue_pop   = 1'b1;
            loaded_in   = 1'b1;
            row_done_in = queue_cmd.row_done;
            bits_in     = expanded;
            left_in     = slot_len;
         end
      end

      rsp_valid   = rsp_valid_ff;
      rsp_payload = rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff    <= 1'b0;
         acc_ff       <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         loaded_ff    <= loaded_in;
         acc_ff       <= acc_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_done_ff <= row_done_in;
      bits_ff     <= bits_in;
      left_ff     <= left_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- hdl/code128b_row_rasterizer.sv -----
// ----------------------------------------------------------------------------
// Code 128 set B row rasterizer
// The first word of a row reaches rsp_valid through the front end's slot states,
// the slot queue, the back end's shift register and the output register; a
// rejected character's result passes the front end's bad state, the queue and
// the output register. Later words follow at most one per cycle. The back end
// loads a slot, then packs it chunk by chunk and takes the next slot only after
// the last chunk, so wider bars cost more per character.
// Reset: synchronous; clears the row state, queue, output register, bar_width=1.
// ----------------------------------------------------------------------------
`include "code128b_row_rasterizer_macros.svh"

module code128b_row_rasterizer (
   input  logic                                   clock,
   input  logic                                   reset,
   // Request channel: one character per request.
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  c128r_pkg::req_payload_type             req_payload,
   // Result channel: one pixel word per result.
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output c128r_pkg::rsp_payload_type             rsp_payload,
   // Configuration port.
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [c128r_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [c128r_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [c128r_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                   csr_pready
);

   // The front end takes a request in its idle state, decides whether the
   // character is valid and queues one command per slot of the row: quiet and
   // start slots when the row opens, the character's symbol, and on the last
   // character the checksum, stop, termination and closing quiet slots. The
   // running checksum goes through a three-step multiply and mod-103 pipeline
   // that finishes before the checksum slot is queued.
   //
   // The back end pops a command, expands the symbol's 11 modules into a
   // 176-pixel shift register scaled by bar_width, and then packs as many
   // pixels as fit into the current 32-pixel word each cycle. A full word,
   // or the last partial word of a row, goes into the output register. The
   // back end stalls only while that register holds a word not yet taken,
   // so results can wait downstream while the front end keeps queuing.

   logic [c128r_pkg::BAR_W_W-1:0]   bar_width_ff, bar_width_in;
   logic                            csr_write;
   logic [c128r_pkg::CSR_IDX_W-1:0] csr_index;

   logic                            queue_push;
   c128r_pkg::slot_cmd_type         queue_push_cmd;
   logic                            queue_full;
   logic                            queue_pop;
   c128r_pkg::slot_cmd_type         queue_pop_cmd;
   logic                            queue_empty;

   // Configuration register: pixels per module, written in the access phase.
   always_comb begin
      csr_pready   = 1'b1;
      csr_index    = csr_paddr[c128r_pkg::CSR_ADDR_W-1:2];
      csr_write    = csr_psel && csr_penable && csr_pwrite && csr_pready;
      bar_width_in = bar_width_ff;
      if (csr_write && (csr_index == c128r_pkg::REG_BAR_WIDTH)) begin
         bar_width_in = csr_pwdata[c128r_pkg::BAR_W_W-1:0];
      end
      if (csr_index == c128r_pkg::REG_BAR_WIDTH) begin
         csr_prdata = c128r_pkg::CSR_DATA_W'(bar_width_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bar_width_ff <= c128r_pkg::BAR_WIDTH_RESET;
      end else begin
         bar_width_ff <= bar_width_in;
      end
   end

   c128r_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_push  (queue_push),
      .queue_cmd   (queue_push_cmd),
      .queue_full  (queue_full)
   );

   c128r_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (queue_push),
      .push_cmd (queue_push_cmd),
      .full     (queue_full),
      .pop      (queue_pop),
      .pop_cmd  (queue_pop_cmd),
      .empty    (queue_empty)
   );

   c128r_back u_back (
      .clock       (clock),
      .reset       (reset),
      .bar_width   (bar_width_ff),
      .queue_empty (queue_empty),
      .queue_cmd   (queue_pop_cmd),
      .queue_pop   (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // A rejected character yields an empty word that closes the row.
   `C128R_ASSERT_IMPLY(a_bad_result_form, clock, reset, rsp_valid && rsp_payload.bad_char, rsp_payload.row_end && (rsp_payload.pixel_count == '0) && (rsp_payload.pixel_word == '0), "bad_char result is not an empty row end")

   // Short words appear only as the last word of a row.
   `C128R_ASSERT_IMPLY(a_partial_at_end, clock, reset, rsp_valid && !rsp_payload.row_end, rsp_payload.pixel_count == c128r_pkg::FILL_W'(c128r_pkg::WORD_PIXELS), "partial word before row end")

   // The front end never pushes a command into a full queue.
   `C128R_ASSERT_IMPLY(a_no_push_when_full, clock, reset, queue_push, !queue_full, "slot command pushed into full queue")

   // After a request is taken the front end is busy queuing its slots.
   `C128R_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "front end ready right after a request")

endmodule

// ----- verif/c128r_row_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Code 128 row rasterizer checker
// Watches the request, result and configuration ports of the rasterizer,
// rebuilds the expected pixel words of every row on its own and compares each
// delivered word with the oldest one still owed.
// ----------------------------------------------------------------------------
module c128r_row_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  c128r_pkg::req_payload_type       req_payload,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  c128r_pkg::rsp_payload_type       rsp_payload,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [c128r_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [c128r_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic [c128r_pkg::CSR_DATA_W-1:0] csr_prdata,
   input  logic                             csr_pready,
   output int                               mismatch_count,
   output int                               words_pending,
   output int                               words_checked,
   output int                               rows_closed,
   output int                               chars_rejected
);

   localparam int ROW_WORD_BITS    = 32;
   localparam int SLOT_MODULES     = 11;
   localparam int WIDEST_MODULE    = 16;
   localparam int BAR_FIELD_BITS   = 5;
   localparam int PATTERN_COUNT    = 109;
   localparam int START_B_SYMBOL   = 104;
   localparam int STOP_SYMBOL      = 106;
   localparam int QUIET_SYMBOL     = 107;
   localparam int TERM_SYMBOL      = 108;
   localparam int CHECKSUM_MODULUS = 103;
   localparam int FIRST_PRINTABLE  = 32;
   localparam int LAST_PRINTABLE   = 126;
   localparam int REPORT_LIMIT     = 10;
   localparam logic [c128r_pkg::CSR_ADDR_W-1:0] BAR_WIDTH_ADDR =
      {c128r_pkg::REG_BAR_WIDTH, 2'b00};

   // Bar/space modules of every symbol, first module in the top bit. The two
   // entries past the stop symbol are the quiet slot and the termination bar.
   localparam logic [SLOT_MODULES-1:0] MODULE_PATTERNS [0:PATTERN_COUNT-1] = '{
      11'b11011001100, 11'b11001101100, 11'b11001100110, 11'b10010011000,
      11'b10010001100, 11'b10001001100, 11'b10011001000, 11'b10011000100,
      11'b10001100100, 11'b11001001000, 11'b11001000100, 11'b11000100100,
      11'b10110011100, 11'b10011011100, 11'b10011001110, 11'b10111001100,
      11'b10011101100, 11'b10011100110, 11'b11001110010, 11'b11001011100,
      11'b11001001110, 11'b11011100100, 11'b11001110100, 11'b11101101110,
      11'b11101001100, 11'b11100101100, 11'b11100100110, 11'b11101100100,
      11'b11100110100, 11'b11100110010, 11'b11011011000, 11'b11011000110,
      11'b11000110110, 11'b10100011000, 11'b10001011000, 11'b10001000110,
      11'b10110001000, 11'b10001101000, 11'b10001100010, 11'b11010001000,
      11'b11000101000, 11'b11000100010, 11'b10110111000, 11'b10110001110,
      11'b10001101110, 11'b10111011000, 11'b10111000110, 11'b10001110110,
      11'b11101110110, 11'b11010001110, 11'b11000101110, 11'b11011101000,
      11'b11011100010, 11'b11011101110, 11'b11101011000, 11'b11101000110,
      11'b11100010110, 11'b11101101000, 11'b11101100010, 11'b11100011010,
      11'b11101111010, 11'b11001000010, 11'b11110001010, 11'b10100110000,
      11'b10100001100, 11'b10010110000, 11'b10010000110, 11'b10000101100,
      11'b10000100110, 11'b10110010000, 11'b10110000100, 11'b10011010000,
      11'b10011000010, 11'b10000110100, 11'b10000110010, 11'b11000010010,
      11'b11001010000, 11'b11110111010, 11'b11000010100, 11'b10001111010,
      11'b10100111100, 11'b10010111100, 11'b10010011110, 11'b10111100100,
      11'b10011110100, 11'b10011110010, 11'b11110100100, 11'b11110010100,
      11'b11110010010, 11'b11011011110, 11'b11011110110, 11'b11110110110,
      11'b10101111000, 11'b10100011110, 11'b10001011110, 11'b10111101000,
      11'b10111100010, 11'b11110101000, 11'b11110100010, 11'b10111011110,
      11'b10111101110, 11'b11101011110, 11'b11110101110, 11'b11010000100,
      11'b11010010000, 11'b11010011100, 11'b11000111010, 11'b00000000000,
      11'b11000000000
   };

   logic [BAR_FIELD_BITS-1:0]  bar_width_q;
   logic                       row_open;
   logic [6:0]                 position_weight;
   logic [6:0]                 running_sum;
   logic [ROW_WORD_BITS-1:0]   pixel_acc;
   logic [5:0]                 pixel_fill;
   c128r_pkg::rsp_payload_type expected_words [$];
   c128r_pkg::rsp_payload_type oldest_word;
   int                         char_value;
   int                         last_idx;

   task automatic count_mismatch(input string note);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%0t: %s", $time, note);
      end
   endtask

   task automatic push_word(input logic [ROW_WORD_BITS-1:0] word, input logic [5:0] count,
                            input logic row_end, input logic bad_char);
      c128r_pkg::rsp_payload_type w;
      w.pixel_word  = word;
      w.pixel_count = count;
      w.row_end     = row_end;
      w.bad_char    = bad_char;
      expected_words.push_back(w);
   endtask

   task automatic drop_row();
      row_open        = 1'b0;
      position_weight = 7'd1;
      running_sum     = 7'(START_B_SYMBOL % CHECKSUM_MODULUS);
      pixel_acc       = '0;
      pixel_fill      = '0;
   endtask

   // Paints one 11-module slot into the word being built, handing off every
   // full word as it completes.
   task automatic paint_slot(input int symbol);
      int                      width;
      int                      m;
      int                      p;
      logic [SLOT_MODULES-1:0] pattern;
      width = (bar_width_q == 0) ? 1 :
              (bar_width_q > WIDEST_MODULE) ? WIDEST_MODULE : int'(bar_width_q);
      pattern = (symbol < PATTERN_COUNT) ? MODULE_PATTERNS[symbol] : '0;
      for (m = 0; m < SLOT_MODULES; m++) begin
         for (p = 0; p < width; p++) begin
            if (pattern[SLOT_MODULES-1-m]) begin
               pixel_acc[ROW_WORD_BITS-1-pixel_fill] = 1'b1;
            end
            pixel_fill++;
            if (pixel_fill == ROW_WORD_BITS) begin
               push_word(pixel_acc, 6'(ROW_WORD_BITS), 1'b0, 1'b0);
               pixel_acc  = '0;
               pixel_fill = '0;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         bar_width_q = 5'd1;
         drop_row();
         expected_words.delete();
         mismatch_count = 0;
         words_checked  = 0;
         rows_closed    = 0;
         chars_rejected = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pready && csr_paddr == BAR_WIDTH_ADDR) begin
            if (csr_pwrite) begin
               bar_width_q = csr_pwdata[BAR_FIELD_BITS-1:0];
            end else if (csr_prdata[BAR_FIELD_BITS-1:0] !== bar_width_q) begin
               count_mismatch($sformatf("bar_width read back %0d, expected %0d",
                                        csr_prdata[BAR_FIELD_BITS-1:0], bar_width_q));
            end
         end

         if (req_valid && !req_stall) begin
            if (req_payload.char_code < FIRST_PRINTABLE ||
                req_payload.char_code > LAST_PRINTABLE) begin
               // Unsupported character: the partial row is thrown away.
               drop_row();
               push_word('0, '0, 1'b1, 1'b1);
            end else begin
               if (!row_open) begin
                  paint_slot(QUIET_SYMBOL);
                  paint_slot(START_B_SYMBOL);
                  row_open = 1'b1;
               end
               char_value = int'(req_payload.char_code) - FIRST_PRINTABLE;
               paint_slot(char_value);
               running_sum = 7'((int'(running_sum) + char_value * int'(position_weight))
                                % CHECKSUM_MODULUS);
               position_weight = 7'((int'(position_weight) + 1) % CHECKSUM_MODULUS);
               if (req_payload.last_char) begin
                  paint_slot(int'(running_sum));
                  paint_slot(STOP_SYMBOL);
                  paint_slot(TERM_SYMBOL);
                  paint_slot(QUIET_SYMBOL);
                  if (pixel_fill != 0) begin
                     push_word(pixel_acc, pixel_fill, 1'b0, 1'b0);
                  end
                  last_idx = expected_words.size() - 1;
                  expected_words[last_idx].row_end = 1'b1;
                  drop_row();
               end
            end
         end

         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               count_mismatch($sformatf("unexpected word %h count %0d end %0b bad %0b",
                                        rsp_payload.pixel_word, rsp_payload.pixel_count,
                                        rsp_payload.row_end, rsp_payload.bad_char));
            end else begin
               oldest_word = expected_words.pop_front();
               if (rsp_payload.pixel_word  !== oldest_word.pixel_word  ||
                   rsp_payload.pixel_count !== oldest_word.pixel_count ||
                   rsp_payload.row_end     !== oldest_word.row_end     ||
                   rsp_payload.bad_char    !== oldest_word.bad_char) begin
                  count_mismatch($sformatf(
                     "expected word %h count %0d end %0b bad %0b, got %h count %0d end %0b bad %0b",
                     oldest_word.pixel_word, oldest_word.pixel_count,
                     oldest_word.row_end, oldest_word.bad_char,
                     rsp_payload.pixel_word, rsp_payload.pixel_count,
                     rsp_payload.row_end, rsp_payload.bad_char));
               end
               words_checked++;
               if (oldest_word.row_end) begin
                  rows_closed++;
               end
               if (oldest_word.bad_char) begin
                  chars_rejected++;
               end
            end
         end

         words_pending = expected_words.size();
      end
   end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Code 128 row rasterizer testbench
// Feeds character requests to the rasterizer under a range of bar widths,
// with random gaps and result back-pressure, and lets the checker beside the
// block confirm every pixel word, row end and rejected character.
// ----------------------------------------------------------------------------
module tb;

   // Cycles the receiver refuses results once during the pressure phase; far
   // longer than the block's internal queue can absorb.
   localparam int HOLD_OFF_CYCLES = 300;
   // Quiet cycles after the last expected word before touching bar_width, to
   // cover a request still in flight that has produced nothing yet.
   localparam int SETTLE_CYCLES   = 40;
   localparam int DRAIN_LIMIT     = 20000;
   localparam int RUN_LIMIT_NS    = 5_000_000;
   localparam int PHASE_COUNT     = 8;
   localparam int PHASE_BUDGET    = 16;
   localparam int LONG_STRING     = 108;
   localparam int PRESSURE_PHASE  = 2;
   localparam int STEADY_PHASE    = 5;
   localparam int LONG_PHASE      = 6;
   localparam int DIRECTED_COUNT  = 21;
   localparam logic [c128r_pkg::CSR_ADDR_W-1:0] BAR_WIDTH_ADDR =
      {c128r_pkg::REG_BAR_WIDTH, 2'b00};

   // Register settings per random phase. They hit the register extremes (0 and
   // 31), the legal extremes (1 and 16) and values just past the legal range.
   // The last phase picks its own width at random.
   localparam logic [4:0] PHASE_WIDTHS [0:PHASE_COUNT-1] = '{
      5'd16, 5'd0, 5'd2, 5'd31, 5'd17, 5'd3, 5'd1, 5'd0
   };

   // Directed requests as {char_code, last_char}: the lowest and highest
   // printable characters as one-character rows, a short string, rejected
   // characters when no row is open, in the middle of a row, flagged as the
   // last character and with every bit of the byte set, then a longer row.
   localparam logic [8:0] DIRECTED_CHARS [0:DIRECTED_COUNT-1] = '{
      {8'd32, 1'b1}, {8'd126, 1'b1},
      {8'd65, 1'b0}, {8'd66, 1'b0}, {8'd67, 1'b1},
      {8'd0, 1'b0},
      {8'd72, 1'b0}, {8'd73, 1'b0}, {8'd31, 1'b0},
      {8'd127, 1'b1},
      {8'd255, 1'b0},
      {8'd90, 1'b0}, {8'd200, 1'b1},
      {8'd48, 1'b0}, {8'd49, 1'b1},
      {8'd100, 1'b0}, {8'd101, 1'b0}, {8'd102, 1'b0}, {8'd103, 1'b0},
      {8'd104, 1'b0}, {8'd125, 1'b1}
   };

   logic                             clock       = 1'b0;
   logic                             reset       = 1'b1;
   logic                             req_valid   = 1'b0;
   logic                             req_stall;
   c128r_pkg::req_payload_type       req_payload = '0;
   logic                             rsp_valid;
   logic                             rsp_stall   = 1'b0;
   c128r_pkg::rsp_payload_type       rsp_payload;
   logic                             csr_psel    = 1'b0;
   logic                             csr_penable = 1'b0;
   logic                             csr_pwrite  = 1'b0;
   logic [c128r_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [c128r_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [c128r_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                             csr_pready;

   // Set by the stimulus: steady turns idling off on both sides, and a rise of
   // hold_off_go starts the long receiver hold-off.
   logic steady        = 1'b0;
   logic hold_off_go   = 1'b0;
   // Owned by the receiver process.
   logic hold_off_seen = 1'b0;
   int   hold_left     = 0;

   int mismatch_count;
   int words_pending;
   int words_checked;
   int rows_closed;
   int chars_rejected;
   int chars_sent  = 0;
   int widths_used = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   code128b_row_rasterizer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   c128r_row_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending),
      .words_checked  (words_checked),
      .rows_closed    (rows_closed),
      .chars_rejected (chars_rejected)
   );

   // Result receiver. It stalls at random with a chance of about a fifth, never during the
   // steady phase, and once holds off for a long stretch so that the block's
   // queue fills and it has to stall the sender.
   always @(posedge clock) begin
      hold_off_seen <= hold_off_go;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_off_go && !hold_off_seen) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_OFF_CYCLES;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (steady) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 19);
      end
   end

   function automatic logic [7:0] good_code();
      return 8'($urandom_range(126, 32));
   endfunction

   // Anything below the space or above the tilde.
   function automatic logic [7:0] bad_code();
      return $urandom_range(1) ? 8'($urandom_range(31, 0)) : 8'($urandom_range(255, 127));
   endfunction

   // Offers one request and returns at the edge where it was taken. Valid is
   // only ever dropped for a random gap ahead of the next request, never
   // because the block stalls.
   task automatic send_char(input logic [7:0] code, input logic last);
      c128r_pkg::req_payload_type item;
      item.char_code = code;
      item.last_char = last;
      if (!steady && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(2, 1)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      chars_sent++;
   endtask

   // One APB transfer to bar_width: setup cycle, access cycle, then a cycle
   // with the port released so that back-to-back calls never collide.
   task automatic csr_access(input logic write, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= BAR_WIDTH_ADDR;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Writes bar_width with junk in the unused upper bits, then reads it back
   // so the checker can compare the stored value.
   task automatic set_bar_width(input logic [4:0] width);
      csr_access(1'b1, ($urandom() & 32'hFFFF_FFE0) | 32'(width));
      csr_access(1'b0, '0);
      widths_used++;
   endtask

   // Lowers valid, waits until every expected word has come out (with a
   // limit), then lets the block settle before the next register write.
   task automatic wait_drained();
      int k;
      req_valid <= 1'b0;
      @(posedge clock);
      for (k = 0; k < DRAIN_LIMIT && words_pending != 0; k++) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random strings. Most are well formed rows of 1 to 12 characters with the
   // last one flagged; some are cut short by a rejected character, and a few
   // requests are lone rejected characters. An optional long string comes
   // first so the position weight wraps around its modulus. Every phase ends
   // with the row closed, since strings are never split across phases.
   task automatic send_strings(input int budget, input int long_len);
      int first;
      int len;
      int cut;
      int k;
      int roll;
      for (k = 0; k < long_len; k++) begin
         send_char(good_code(), k == long_len - 1);
      end
      first = chars_sent;
      while (chars_sent - first < budget) begin
         roll = $urandom_range(99);
         if (roll < 8) begin
            send_char(bad_code(), 1'($urandom_range(1)));
         end else begin
            len = $urandom_range(12, 1);
            cut = (roll < 20) ? $urandom_range(len - 1, 0) : len;
            for (k = 0; k < len && k <= cut; k++) begin
               if (k == cut) begin
                  send_char(bad_code(), 1'($urandom_range(1)));
               end else begin
                  send_char(good_code(), k == len - 1);
               end
            end
         end
      end
   endtask

   initial begin
      int         i;
      int         phase;
      logic [4:0] width;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset width, written explicitly anyway.
      set_bar_width(5'd1);
      for (i = 0; i < DIRECTED_COUNT; i++) begin
         send_char(DIRECTED_CHARS[i][8:1], DIRECTED_CHARS[i][0]);
      end
      wait_drained();

      // Random phases, each under its own bar_width and only written once the
      // block has gone quiet.
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         width = (phase == PHASE_COUNT - 1) ? 5'($urandom_range(31, 0)) : PHASE_WIDTHS[phase];
         set_bar_width(width);
         steady      <= (phase == STEADY_PHASE);
         hold_off_go <= (phase == PRESSURE_PHASE);
         send_strings(PHASE_BUDGET, (phase == LONG_PHASE) ? LONG_STRING : 0);
         wait_drained();
      end

      $display("Sent %0d character requests under %0d bar_width settings, including a long",
               chars_sent, widths_used);
      $display("receiver hold-off; checked %0d pixel words, %0d row ends, %0d rejected characters.",
               words_checked, rows_closed, chars_rejected);
      if (words_pending != 0) begin
         $display("%0d expected pixel words never arrived", words_pending);
      end
      if (mismatch_count == 0 && words_pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("Run limit reached with %0d pixel words outstanding", words_pending);
      $display("== FAIL ==");
      $finish;
   end

endmodule
